/* design/pwmp_pkg.sv */
package pwmp_pkg;

  // width of the configuration write data
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 3;

  // reset value of the period register before truncation to its width
  localparam logic [CFG_DATA_W-1:0] PERIOD_RESET = 32'd65534;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_PRESCALE     = 3'd1,
    REG_PERIOD       = 3'd2,
    REG_SAMPLE       = 3'd3,
    REG_ACTIVE_LOW   = 3'd4,
    REG_IRQ_ENABLE   = 3'd5
  } reg_index_t;

  // item kinds
  typedef enum logic {
    MODE_TICK   = 1'b0,
    MODE_STATUS = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  clear_rollover;
  } in_data_t;

  typedef struct packed {
    logic pwm_level;
    logic rollover_status;
    logic irq_line;
  } out_data_t;

  // single-bit control registers
  typedef struct packed {
    logic enable;
    logic active_low;
    logic irq_enable;
  } ctrl_t;

endpackage

/* design/pwmp_regs.sv */
module pwmp_regs #(
  parameter int PERIOD_BITS = 16,
  parameter int PRESCALE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwmp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pwmp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pwmp_pkg::ctrl_t                     ctrl,
  output logic [PRESCALE_BITS-1:0]            prescale_minus_one,
  output logic [PERIOD_BITS-1:0]              period_minus_two,
  output logic [PERIOD_BITS-1:0]              sample
);

  logic cfg_write;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  // register file, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl               <= '0;
      prescale_minus_one <= '0;
      period_minus_two   <= PERIOD_BITS'(pwmp_pkg::PERIOD_RESET);
      sample             <= '0;
    end else if (cfg_write) begin
      case (pwmp_pkg::reg_index_t'(cfg_index))
        pwmp_pkg::REG_ENABLE:     ctrl.enable <= cfg_data[0];
        pwmp_pkg::REG_PRESCALE:   prescale_minus_one <= cfg_data[PRESCALE_BITS-1:0];
        pwmp_pkg::REG_PERIOD:     period_minus_two <= cfg_data[PERIOD_BITS-1:0];
        pwmp_pkg::REG_SAMPLE:     sample <= cfg_data[PERIOD_BITS-1:0];
        pwmp_pkg::REG_ACTIVE_LOW: ctrl.active_low <= cfg_data[0];
        pwmp_pkg::REG_IRQ_ENABLE: ctrl.irq_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* design/pwmp_count.sv */
module pwmp_count #(
  parameter int PERIOD_BITS = 16,
  parameter int PRESCALE_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     tick,
  input  logic                     clear,
  input  logic                     enable,
  input  logic [PRESCALE_BITS-1:0] prescale_minus_one,
  input  logic [PERIOD_BITS-1:0]   period_minus_two,
  output logic [PERIOD_BITS:0]     period_count_next,
  output logic                     rollover_flag_next
);

  logic [PRESCALE_BITS-1:0] prescale_count;
  logic [PRESCALE_BITS-1:0] prescale_count_next;
  logic [PERIOD_BITS:0]     period_count;
  logic                     rollover_flag;
  logic [PERIOD_BITS:0]     period_last;
  logic                     prescale_wrap;
  logic                     period_wrap;

  // wrap points, a count past its limit wraps on the next advance
  assign period_last   = {1'b0, period_minus_two} + (PERIOD_BITS+1)'(1);
  assign prescale_wrap = prescale_count >= prescale_minus_one;
  assign period_wrap   = period_count >= period_last;

  // next state for one item
  always_comb begin
    prescale_count_next = prescale_count;
    period_count_next   = period_count;
    rollover_flag_next  = rollover_flag;
    if (tick) begin
      if (!enable) begin
        prescale_count_next = '0;
        period_count_next   = '0;
      end else if (prescale_wrap) begin
        prescale_count_next = '0;
        if (period_wrap) begin
          period_count_next  = '0;
          rollover_flag_next = 1'b1;
        end else begin
          period_count_next = period_count + (PERIOD_BITS+1)'(1);
        end
      end else begin
        prescale_count_next = prescale_count + PRESCALE_BITS'(1);
      end
    end else if (clear) begin
      rollover_flag_next = 1'b0;
    end
  end

  // counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      period_count   <= '0;
      rollover_flag  <= 1'b0;
    end else begin
      prescale_count <= prescale_count_next;
      period_count   <= period_count_next;
      rollover_flag  <= rollover_flag_next;
    end
  end

`ifndef SYNTHESIS
  // a disabled tick parks both counters at zero
  assert property (@(posedge clk) disable iff (rst)
    tick && !enable |=> prescale_count == '0 && period_count == '0)
    else $error("counters not parked after disabled tick");

  // the flag is only set by a period wrap on a tick
  assert property (@(posedge clk) disable iff (rst)
    $rose(rollover_flag) |-> $past(tick) && $past(period_wrap) && $past(enable))
    else $error("rollover flag set without a period wrap");

  // the flag is only cleared by a status write or reset
  assert property (@(posedge clk) disable iff (rst)
    $fell(rollover_flag) |-> $past(clear) || $past(rst))
    else $error("rollover flag cleared without a status write");

  // a wrapping period counter always restarts from zero
  assert property (@(posedge clk) disable iff (rst)
    tick && enable && prescale_wrap && period_wrap |=> period_count == '0 && rollover_flag)
    else $error("period wrap did not restart the counter");
`endif

endmodule

/* design/pwm_generator_with_prescaler_unit.sv */
// PWM timer with prescaler. Each input transfer is either one peripheral clock
// tick or one status register write; every transfer yields exactly one result
// carrying the pin level, the sticky rollover flag and the interrupt line as
// they stand after that transfer. A tick with enable set advances the prescaler,
// and each prescaler wrap advances the period counter, which counts from zero to
// period_minus_two+1 and sets the rollover flag when it wraps. The pin is active
// while enabled and the period count is below sample; active_low inverts it. The
// block takes one transfer per cycle while the output is not stalled: the counter
// update is a single compare-and-increment between the state registers, and the
// result sits in a one-deep output register, refilled in the same cycle it is taken.
// Configuration writes are accepted at any time with no wait.
module pwm_generator_with_prescaler_unit #(
  parameter int PERIOD_BITS = 16,
  parameter int PRESCALE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pwmp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pwmp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pwmp_pkg::in_data_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pwmp_pkg::out_data_t              out_data
);

  pwmp_pkg::ctrl_t          ctrl;
  logic [PRESCALE_BITS-1:0] prescale_minus_one;
  logic [PERIOD_BITS-1:0]   period_minus_two;
  logic [PERIOD_BITS-1:0]   sample;
  logic [PERIOD_BITS:0]     period_count_next;
  logic                     rollover_flag_next;
  logic                     in_transfer;
  logic                     tick;
  logic                     clear;
  logic                     active;
  pwmp_pkg::out_data_t      out_data_next;

  pwmp_regs #(
    .PERIOD_BITS   (PERIOD_BITS),
    .PRESCALE_BITS (PRESCALE_BITS)
  ) u_regs (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .ctrl               (ctrl),
    .prescale_minus_one (prescale_minus_one),
    .period_minus_two   (period_minus_two),
    .sample             (sample)
  );

  // input transfer decode
  assign in_ready    = !out_valid || out_ready;
  assign in_transfer = in_valid && in_ready;
  assign tick        = in_transfer && (in_data.mode == pwmp_pkg::MODE_TICK);
  assign clear       = in_transfer && (in_data.mode == pwmp_pkg::MODE_STATUS)
                       && in_data.clear_rollover;

  pwmp_count #(
    .PERIOD_BITS   (PERIOD_BITS),
    .PRESCALE_BITS (PRESCALE_BITS)
  ) u_count (
    .clk                (clk),
    .rst                (rst),
    .tick               (tick),
    .clear              (clear),
    .enable             (ctrl.enable),
    .prescale_minus_one (prescale_minus_one),
    .period_minus_two   (period_minus_two),
    .period_count_next  (period_count_next),
    .rollover_flag_next (rollover_flag_next)
  );

  // result from the state after this transfer
  assign active = ctrl.enable && (period_count_next < {1'b0, sample});
  always_comb begin
    out_data_next.pwm_level       = active ^ ctrl.active_low;
    out_data_next.rollover_status = rollover_flag_next;
    out_data_next.irq_line        = rollover_flag_next & ctrl.irq_enable;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_transfer) begin
      out_data <= out_data_next;
    end
  end

endmodule
